// ===== rtl/core/swam_pkg.sv =====
// ----------------------------------------------------------------------------
// swam_pkg
// Shared types and fixed field widths for the sliding window anagram matcher.
// ----------------------------------------------------------------------------
package swam_pkg;

  // Width of a letter field (a=0 .. z=25, up to 31 representable)
  localparam int LETTER_W = 5;

  // Stream widths: letter in s_tdata, opcode in s_tuser, three flags in m_tdata
  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;

  // Request kinds carried on s_tuser; the remaining code means nothing
  typedef enum logic [S_TUSER_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } swam_op_t;

endpackage

// ===== rtl/core/sliding_window_anagram_match.sv =====
// ----------------------------------------------------------------------------
// sliding_window_anagram_match
// Reports, per text letter, whether the last L letters are a permutation of
// a pattern of length L, plus a sticky found flag.
// ----------------------------------------------------------------------------
// Usage
//   Input requests arrive on s_tvalid/s_tready. s_tuser gives the kind: clear
//   (start a job), pattern letter or text letter; s_tdata[4:0] is the letter
//   and s_tlast marks the final text letter. Letters at or above ALPHABET and
//   the unused kind are dropped silently.
//   Only text letters produce a result on m_tvalid/m_tready: m_tdata[0] is
//   window_match, [1] found, [2] overflow, and m_tlast echoes s_tlast.
//   Pattern letters past MAX_PATTERN are dropped and raise overflow until the
//   next clear; pattern letters after text has started are dropped too.
// Timing
//   One request is taken per cycle while s_tready is high. A result is
//   registered, appearing in the cycle after its text letter is taken. Both
//   histograms and the mismatch count are updated in a single pass; the ring
//   buffer reads the leaving letter ahead into a register, with write bypass.
//   When the result register is full and m_tready is low, s_tready drops.
// Reset
//   rst (synchronous) returns the block to an empty job; the ring buffer
//   contents are not cleared, as no entry is read before it is rewritten.
// ----------------------------------------------------------------------------
module sliding_window_anagram_match
  import swam_pkg::*;
#(
  parameter int MAX_PATTERN = 256,
  parameter int ALPHABET    = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] letter, [7:5] zero
  input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] opcode
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [0] window_match, [1] found,
                                          // [2] overflow, [7:3] zero
  output logic                 m_tlast
);

  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int SYM_W = $clog2(ALPHABET);
  localparam int MIS_W = $clog2(ALPHABET + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_PATTERN - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W:0]   RING_LEN = (LEN_W + 1)'(MAX_PATTERN);

  // Job state
  logic [LEN_W-1:0]    pat_cnt [ALPHABET];
  logic [LEN_W-1:0]    win_cnt [ALPHABET];
  logic [LEN_W-1:0]    pat_cnt_next [ALPHABET];
  logic [LEN_W-1:0]    win_cnt_next [ALPHABET];
  logic [MIS_W-1:0]    mismatch, mismatch_next;
  logic [LEN_W-1:0]    pattern_length, pattern_length_next;
  logic [LEN_W-1:0]    text_seen, text_seen_next;
  logic [PTR_W-1:0]    ring_ptr, ring_ptr_next;
  logic                found_flag, found_flag_next;
  logic                overflow_flag, overflow_flag_next;
  logic                text_started, text_started_next;

  // Ring buffer and its read-ahead port
  logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];
  logic [LETTER_W-1:0] old_letter;
  logic [PTR_W-1:0]    rd_addr;
  logic [LEN_W:0]      rd_base;

  // Result register
  logic                out_valid;
  logic                out_match, out_found, out_overflow, out_last;

  // Request decode
  swam_op_t            op;
  logic [LETTER_W-1:0] letter;
  logic [SYM_W-1:0]    sym_idx, old_idx;
  logic                s_fire, sym_ok;
  logic                is_clear, is_pat, pat_add, pat_drop, is_txt, txt_win;
  logic                win_full, win_drop, match;
  logic [ALPHABET-1:0] lane_up, lane_dn, lane_neq;

  assign op       = swam_op_t'(s_tuser);
  assign letter   = s_tdata[LETTER_W-1:0];
  assign sym_idx  = SYM_W'(letter);
  assign old_idx  = SYM_W'(old_letter);
  assign s_tready = !out_valid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign sym_ok   = {4'd0, letter} < 9'(ALPHABET);

  assign is_clear = s_fire && (op == OP_CLEAR);
  assign is_pat   = s_fire && (op == OP_PATTERN) && sym_ok && !text_started;
  assign pat_add  = is_pat && (pattern_length != LEN_MAX);
  assign pat_drop = is_pat && (pattern_length == LEN_MAX);
  assign is_txt   = s_fire && (op == OP_TEXT) && sym_ok;
  // An empty pattern bypasses the window entirely
  assign txt_win  = is_txt && (pattern_length != '0);
  assign win_full = (text_seen == pattern_length);
  assign win_drop = txt_win && win_full;

  // Per-letter lanes: each count moves by at most one step up and one down
  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      pat_cnt_next[i] = pat_cnt[i] + LEN_W'(pat_add && (sym_idx == SYM_W'(i)));
      win_cnt_next[i] = win_cnt[i] + LEN_W'(txt_win && (sym_idx == SYM_W'(i)))
                        - LEN_W'(win_drop && (old_idx == SYM_W'(i)));
      lane_neq[i] = (pat_cnt[i] != win_cnt[i]);
      lane_up[i]  = !lane_neq[i] && (pat_cnt_next[i] != win_cnt_next[i]);
      lane_dn[i]  = lane_neq[i] && (pat_cnt_next[i] == win_cnt_next[i]);
    end
  end

  always_comb begin
    mismatch_next       = MIS_W'(int'(mismatch) + $countones(lane_up)
                                 - $countones(lane_dn));
    pattern_length_next = pattern_length + LEN_W'(pat_add);
    text_seen_next      = text_seen + LEN_W'(txt_win && !win_full);
    ring_ptr_next       = ring_ptr;
    if (txt_win) begin
      ring_ptr_next = (ring_ptr == PTR_LAST) ? '0 : ring_ptr + PTR_W'(1);
    end
    overflow_flag_next  = overflow_flag || pat_drop;
    text_started_next   = text_started || is_txt;
    match = (pattern_length == '0) ||
            ((text_seen_next == pattern_length) && (mismatch_next == '0));
    found_flag_next     = found_flag || (is_txt && match);
    if (is_clear) begin
      mismatch_next       = '0;
      pattern_length_next = '0;
      text_seen_next      = '0;
      ring_ptr_next       = '0;
      overflow_flag_next  = 1'b0;
      text_started_next   = 1'b0;
      found_flag_next     = 1'b0;
    end
  end

  // Address of the letter that leaves the window on the next text letter
  always_comb begin
    rd_base = (LEN_W + 1)'(ring_ptr_next);
    if (rd_base < (LEN_W + 1)'(pattern_length_next)) begin
      rd_base = rd_base + RING_LEN;
    end
    rd_addr = PTR_W'(rd_base - (LEN_W + 1)'(pattern_length_next));
  end

  // Ring buffer: write the new letter, read ahead with bypass on collision
  always_ff @(posedge clk) begin
    if (txt_win) begin
      ring_mem[ring_ptr] <= letter;
    end
    if (txt_win && (rd_addr == ring_ptr)) begin
      old_letter <= letter;
    end else begin
      old_letter <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHABET; i++) begin
        pat_cnt[i] <= '0;
        win_cnt[i] <= '0;
      end
      mismatch       <= '0;
      pattern_length <= '0;
      text_seen      <= '0;
      ring_ptr       <= '0;
      found_flag     <= 1'b0;
      overflow_flag  <= 1'b0;
      text_started   <= 1'b0;
    end else begin
      for (int i = 0; i < ALPHABET; i++) begin
        pat_cnt[i] <= is_clear ? '0 : pat_cnt_next[i];
        win_cnt[i] <= is_clear ? '0 : win_cnt_next[i];
      end
      mismatch       <= mismatch_next;
      pattern_length <= pattern_length_next;
      text_seen      <= text_seen_next;
      ring_ptr       <= ring_ptr_next;
      found_flag     <= found_flag_next;
      overflow_flag  <= overflow_flag_next;
      text_started   <= text_started_next;
    end
  end

  // Result register: load on a text letter, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_txt) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (is_txt) begin
      out_match    <= match;
      out_found    <= found_flag_next;
      out_overflow <= overflow_flag;
      out_last     <= s_tlast;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W - 3)'(0), out_overflow, out_found, out_match};
  assign m_tlast  = out_last;

  // Checks
  a_mismatch_exact: assert property (@(posedge clk) disable iff (rst)
    mismatch == MIS_W'($countones(lane_neq)))
    else $error("mismatch count disagrees with histograms");

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    text_seen <= pattern_length)
    else $error("text_seen passed pattern length");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ring_ptr <= PTR_LAST)
    else $error("ring pointer out of range");

  a_match_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_match |-> out_found)
    else $error("match reported without found");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    is_clear |=> (pattern_length == '0) && !found_flag && !text_started)
    else $error("clear left job state behind");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window anagram matcher. A short table of
// hand-picked requests covers the corner cases. Random jobs follow: a clear,
// a pattern, then text built mostly from shuffled copies of the pattern, with
// ignored requests mixed in. Every result is checked against a local
// histogram model or a typed table row, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb
  import swam_pkg::*;
;

  localparam int ALPHA       = 26;
  localparam int MAX_PAT     = 256;
  localparam int RANDOM_REQS = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int IDLE_PCT    = 26;
  localparam int DRAIN_WAIT  = 8;

  // The one kind code that the block must drop
  localparam logic [S_TUSER_W-1:0] OP_UNUSED = 2'd3;

  // Packed so that bit i matches {m_tlast, m_tdata[2:0]} bit i
  typedef struct packed {
    logic is_last;
    logic overflow;
    logic found;
    logic window_match;
  } verdict_t;

  typedef struct packed {
    logic [S_TUSER_W-1:0] op;
    logic [LETTER_W-1:0]  ltr;
    logic                 lst;
    bit                   typed;
    verdict_t             exp;
  } dir_row_t;

  localparam int N_DIR = 22;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  sliding_window_anagram_match #(
    .MAX_PATTERN(MAX_PAT),
    .ALPHABET   (ALPHA)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Histogram model of the block
  // --------------------------------------------------------------------------
  logic [8:0]          pat_hist [ALPHA];
  logic [8:0]          win_hist [ALPHA];
  logic [4:0]          diff_letters;
  logic [8:0]          pat_len;
  logic [8:0]          seen;
  logic [LETTER_W-1:0] history [MAX_PAT];
  logic [7:0]          wr_ptr;
  bit                  found_q;
  bit                  ovf_q;
  bit                  text_on;

  verdict_t expected_verdicts [$];
  int       n_errors  = 0;
  int       n_sent    = 0;
  int       n_results = 0;
  int       stall_cycles = 0;
  string    field_names [0:3] = '{"window_match", "found", "overflow", "is_last"};

  // Stretches of the run with no idling: tx_calm on the request side, rx_calm on the result side
  wire tx_calm = (n_sent >= 250) && (n_sent < 400);
  wire rx_calm = (n_results >= 30) && (n_results < 100);

  // Return the job to empty; the letter history needs no clearing
  function automatic void clear_job();
    for (int i = 0; i < ALPHA; i++) begin
      pat_hist[i] = '0;
      win_hist[i] = '0;
    end
    diff_letters = '0;
    pat_len      = '0;
    seen         = '0;
    wr_ptr       = '0;
    found_q      = 1'b0;
    ovf_q        = 1'b0;
    text_on      = 1'b0;
  endfunction

  // Move one histogram entry by one and keep the count of differing letters
  function automatic void step_count(input bit on_window, input logic [LETTER_W-1:0] sym,
                                     input bit up);
    bit was_equal;
    bit now_equal;
    was_equal = pat_hist[sym] == win_hist[sym];
    if (on_window) begin
      if (up) win_hist[sym] = win_hist[sym] + 1'b1;
      else if (win_hist[sym] != 0) win_hist[sym] = win_hist[sym] - 1'b1;
    end else begin
      pat_hist[sym] = pat_hist[sym] + 1'b1;
    end
    now_equal = pat_hist[sym] == win_hist[sym];
    if (was_equal && !now_equal) diff_letters = diff_letters + 1'b1;
    else if (!was_equal && now_equal && diff_letters != 0) diff_letters = diff_letters - 1'b1;
  endfunction

  // Advance the model by one accepted request; return 1 when it yields a result
  function automatic bit predict_request(input logic [S_TUSER_W-1:0] op,
                                         input logic [LETTER_W-1:0] ltr, input logic lst,
                                         output verdict_t v);
    logic [7:0] old_idx;
    v = '0;
    if (op == OP_CLEAR) begin
      clear_job();
      return 1'b0;
    end
    if (op != OP_PATTERN && op != OP_TEXT) return 1'b0;
    if (ltr >= ALPHA) return 1'b0;
    if (op == OP_PATTERN) begin
      if (text_on) return 1'b0;
      if (pat_len >= MAX_PAT) begin
        ovf_q = 1'b1;
        return 1'b0;
      end
      pat_len = pat_len + 1'b1;
      step_count(1'b0, ltr, 1'b1);
      return 1'b0;
    end
    text_on = 1'b1;
    if (pat_len == 0) begin
      v.window_match = 1'b1;
    end else begin
      if (seen >= pat_len) begin
        // Full window: add the newcomer, drop the letter that leaves
        old_idx = wr_ptr - pat_len[7:0];
        step_count(1'b1, ltr, 1'b1);
        step_count(1'b1, history[old_idx], 1'b0);
      end else begin
        step_count(1'b1, ltr, 1'b1);
        seen = seen + 1'b1;
      end
      history[wr_ptr] = ltr;
      wr_ptr = wr_ptr + 1'b1;
      v.window_match = (seen == pat_len) && (diff_letters == 0);
    end
    if (v.window_match) found_q = 1'b1;
    v.found    = found_q;
    v.overflow = ovf_q;
    v.is_last  = lst;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Request side: idle at random, hold the request until it is taken, then
  // queue what the model expects from it
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [S_TUSER_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                              input logic lst, input bit typed, input verdict_t typed_v);
    verdict_t v;
    bit       has_res;
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - LETTER_W){1'b0}}, ltr};
    s_tuser  <= op;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    has_res = predict_request(op, ltr, lst, v);
    if (typed) expected_verdicts.push_back(typed_v);
    else if (has_res) expected_verdicts.push_back(v);
  endtask

  // Send one request that the block must drop, or a pattern letter in the text phase
  task automatic send_noise(input bit text_phase);
    int kind;
    kind = $urandom_range(2);
    if (kind == 0)
      send_request(OP_UNUSED, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)),
                   1'b0, '0);
    else if (kind == 1 || !text_phase)
      send_request($urandom_range(1) ? OP_TEXT : OP_PATTERN,
                   LETTER_W'($urandom_range(31, ALPHA)), 1'($urandom_range(1)), 1'b0, '0);
    else
      send_request(OP_PATTERN, LETTER_W'($urandom_range(ALPHA - 1)),
                   1'($urandom_range(1)), 1'b0, '0);
  endtask

  // Most jobs draw their letters from a small run of the alphabet, so windows repeat
  int letter_base;
  int letter_span;

  function automatic logic [LETTER_W-1:0] pick_letter();
    return LETTER_W'((letter_base + $urandom_range(letter_span - 1)) % ALPHA);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each taken result against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    verdict_t got;
    verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = verdict_t'({m_tlast, m_tdata[2:0]});
        n_results++;
        if (expected_verdicts.size() == 0) begin
          note_mismatch($sformatf("result %b with nothing expected", got));
        end else begin
          want = expected_verdicts.pop_front();
          for (int i = 0; i < 4; i++)
            if (got[i] !== want[i])
              note_mismatch($sformatf("result %0d %s: got %b, want %b", n_results,
                                      field_names[i], got[i], want[i]));
        end
      end
      m_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Abort when no request moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[%0t] watchdog: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t                  dir_rows [N_DIR];
    logic [LETTER_W-1:0]       pat_letters [$];
    logic [LETTER_W-1:0]       plan [$];
    logic [LETTER_W-1:0]       swap;
    int                        n_counted;
    int                        job;
    int                        len;
    int                        text_len;
    int                        perm_pct;
    int                        j;
    int                        r;

    clear_job();
    // Columns: kind, letter, last, typed, expected {last, overflow, found, match}
    dir_rows = '{
      // No pattern after reset: every text letter matches
      '{OP_TEXT,    5'd0,  1'b0, 1'b1, 4'b0011},
      '{OP_TEXT,    5'd25, 1'b1, 1'b1, 4'b1011},
      // Pattern letter once text has begun: drop
      '{OP_PATTERN, 5'd3,  1'b0, 1'b0, 4'b0000},
      '{OP_UNUSED,  5'd5,  1'b0, 1'b0, 4'b0000},
      '{OP_CLEAR,   5'd31, 1'b1, 1'b0, 4'b0000},
      // Out-of-range text letter is dropped and does not close the pattern
      '{OP_TEXT,    5'd31, 1'b0, 1'b0, 4'b0000},
      '{OP_PATTERN, 5'd0,  1'b0, 1'b0, 4'b0000},
      '{OP_PATTERN, 5'd25, 1'b0, 1'b0, 4'b0000},
      '{OP_PATTERN, 5'd30, 1'b0, 1'b0, 4'b0000},
      // Window not yet full, then full and a permutation
      '{OP_TEXT,    5'd25, 1'b0, 1'b1, 4'b0000},
      '{OP_TEXT,    5'd0,  1'b0, 1'b1, 4'b0011},
      '{OP_TEXT,    5'd16, 1'b0, 1'b0, 4'b0000},
      '{OP_TEXT,    5'd0,  1'b1, 1'b0, 4'b0000},
      // Text carries on past a last flag
      '{OP_TEXT,    5'd25, 1'b0, 1'b0, 4'b0000},
      '{OP_CLEAR,   5'd0,  1'b0, 1'b0, 4'b0000},
      // Repeated letter in the pattern
      '{OP_PATTERN, 5'd16, 1'b0, 1'b0, 4'b0000},
      '{OP_PATTERN, 5'd16, 1'b0, 1'b0, 4'b0000},
      '{OP_TEXT,    5'd16, 1'b0, 1'b1, 4'b0000},
      '{OP_TEXT,    5'd15, 1'b0, 1'b0, 4'b0000},
      '{OP_TEXT,    5'd16, 1'b1, 1'b0, 4'b0000},
      // Clear after a pattern job brings back the empty pattern
      '{OP_CLEAR,   5'd0,  1'b0, 1'b0, 4'b0000},
      '{OP_TEXT,    5'd7,  1'b0, 1'b1, 4'b0011}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_request(dir_rows[i].op, dir_rows[i].ltr, dir_rows[i].lst, dir_rows[i].typed,
                   dir_rows[i].exp);

    // Random jobs; the third one overfills the pattern
    n_counted = 0;
    job = 0;
    while (n_counted < RANDOM_REQS) begin
      job++;
      letter_base = $urandom_range(ALPHA - 1);
      letter_span = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : ALPHA;
      send_request(OP_CLEAR, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)),
                   1'b0, '0);
      n_counted++;

      r = $urandom_range(99);
      if (job == 3) len = MAX_PAT + 2;
      else if (r < 10) len = 0;
      else if (r < 75) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 24);

      pat_letters.delete();
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 6) send_noise(1'b0);
        plan.push_back(pick_letter());
        if (pat_letters.size() < MAX_PAT) pat_letters.push_back(plan[$]);
        send_request(OP_PATTERN, plan.pop_back(), 1'($urandom_range(1)), 1'b0, '0);
        n_counted++;
      end

      if (len > MAX_PAT) begin
        text_len = $urandom_range(8, 24);
        perm_pct = 100;
      end else begin
        text_len = $urandom_range(1, 3 * len + 6);
        perm_pct = 60;
      end

      // Build text mostly from shuffled copies of the pattern, with filler
      plan.delete();
      for (int i = 0; i < text_len; i++) begin
        if (plan.size() == 0) begin
          if (len > 0 && $urandom_range(99) < perm_pct) begin
            plan = pat_letters;
            for (j = plan.size() - 1; j > 0; j--) begin
              r = $urandom_range(j);
              swap = plan[j];
              plan[j] = plan[r];
              plan[r] = swap;
            end
          end else begin
            repeat ($urandom_range(1, 3)) plan.push_back(pick_letter());
          end
        end
        if ($urandom_range(99) < 6) send_noise(1'b1);
        send_request(OP_TEXT, plan.pop_front(),
                     (i == text_len - 1) || ($urandom_range(99) < 8), 1'b0, '0);
        n_counted++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then give a late or extra result time to show up
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
